// ===== rtl/dct3d_pkg.sv =====
// Package with shared types, widths and the cosine table for the 3D DCT block.
package dct3d_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W = 24;
   localparam int WORK_W   = 40;
   localparam int ACC_W    = 60;
   localparam int COEF_W   = 18;
   localparam int BIT_W    = 5;
   localparam int IDX_W    = 6;
   localparam int COORD_W  = 2;

   // Saturation limits of the result field.
   localparam logic signed [WORK_W-1:0] SAT_MAX = 40'sd8388607;
   localparam logic signed [WORK_W-1:0] SAT_MIN = -40'sd8388608;

   // Register index of the mode register.
   localparam logic REG_MODE = 1'b0;

   // Control word from the sequencer to the serial multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic load;
      logic run;
   } mac_ctl_type;

   // Orthonormal cosine table, [length-1][k][n], scaled by 2^16.
   localparam logic signed [COEF_W-1:0] COS_ROM [0:63] = '{
      18'sd65536, 18'sd0, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd46341, 18'sd46341, 18'sd0, 18'sd0,
      18'sd46341, -18'sd46341, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd37837, 18'sd37837, 18'sd37837, 18'sd0,
      18'sd46341, 18'sd0, -18'sd46341, 18'sd0,
      18'sd26755, -18'sd53510, 18'sd26755, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd32768, 18'sd32768, 18'sd32768, 18'sd32768,
      18'sd42813, 18'sd17734, -18'sd17734, -18'sd42813,
      18'sd32768, -18'sd32768, -18'sd32768, 18'sd32768,
      18'sd17734, -18'sd42813, 18'sd42813, -18'sd17734
   };

   // Look up one table entry.
   function automatic logic signed [COEF_W-1:0] cos_coef(
      input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] k,
      input logic [COORD_W-1:0] n
   );
      return COS_ROM[{row, k, n}];
   endfunction

endpackage

// ===== rtl/dct3d_mac.sv =====
// Bit-serial multiply-accumulate unit: one coefficient bit per cycle while run is set.
module dct3d_mac
   import dct3d_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctl_type              ctl,
   input  logic signed [WORK_W-1:0] x_value,
   input  logic signed [COEF_W-1:0] c_value,
   output logic signed [ACC_W-1:0]  acc_out,
   output logic                     last_bit
);

   logic signed [ACC_W-1:0]  x_ff, x_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic        [COEF_W-1:0] c_ff, c_in;
   logic        [BIT_W-1:0]  bit_ff, bit_in;

   assign last_bit = (bit_ff == BIT_W'(COEF_W - 1));
   assign acc_out  = acc_ff;

   // Shift-add step; the top coefficient bit carries negative weight.
   always_comb begin
      x_in   = x_ff;
      c_in   = c_ff;
      bit_in = bit_ff;
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end
      if (ctl.load) begin
         x_in   = ACC_W'(x_value);
         c_in   = c_value;
         bit_in = '0;
      end else if (ctl.run) begin
         if (c_ff[0]) begin
            acc_in = last_bit ? (acc_ff - x_ff) : (acc_ff + x_ff);
         end
         x_in   = x_ff <<< 1;
         c_in   = c_ff >> 1;
         bit_in = bit_ff + BIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
         acc_ff <= '0;
      end else begin
         bit_ff <= bit_in;
         acc_ff <= acc_in;
      end
      x_ff <= x_in;
      c_ff <= c_in;
   end

`ifndef NO_ASSERTIONS
   // The bit counter never runs past the last coefficient bit.
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      ctl.run && !ctl.load |-> bit_ff <= BIT_W'(COEF_W - 1))
      else $error("mac bit counter overrun");
   // A load restarts the bit counter.
   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> bit_ff == '0)
      else $error("mac load did not restart");
   // Clearing empties the accumulator.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clear && !ctl.run |=> acc_ff == '0)
      else $error("mac clear failed");
`endif

endmodule

// ===== rtl/dct_3d_block_fwd_inv.sv =====
// Top level of the 3D DCT-II / DCT-III block with its sequencer and work memory.
//
// The block collects BLOCK_SIDE*BLOCK_SIDE*GROUP_DEPTH samples (depth, row, column
// order), then runs three one-axis passes (columns, rows, depth) with a single
// bit-serial multiply-accumulate unit, and finally emits every coefficient in the
// same order, with last on the final one. Each multiply term passes through a read,
// an operand load and the bit-serial multiply over all coefficient bits, and each
// written element adds a write step; each emitted item takes a read and a show step.
// Inputs are not taken while a cube is processed or emitted.
// The mode register is sampled when the last sample of a cube is taken.
module dct_3d_block_fwd_inv
   import dct3d_pkg::*;
#(
   parameter int BLOCK_SIDE  = 4,
   parameter int GROUP_DEPTH = 4
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_coefficient,
   output logic        [IDX_W-1:0]    rsp_out_index,
   output logic                       rsp_last,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic        [2:0]          csr_paddr,
   input  logic        [31:0]         csr_pwdata,
   output logic        [31:0]         csr_prdata,
   output logic                       csr_pready
);

   localparam logic [IDX_W:0] TOTAL = (IDX_W+1)'(BLOCK_SIDE * BLOCK_SIDE * GROUP_DEPTH);
   localparam logic [COORD_W-1:0] SIDE_MAX  = COORD_W'(BLOCK_SIDE - 1);
   localparam logic [COORD_W-1:0] DEPTH_MAX = COORD_W'(GROUP_DEPTH - 1);

   // Sequencer states.
   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_ORD  = 3'd5;
   localparam logic [2:0] S_SHOW = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               mode_ff, mode_in;
   logic               inv_ff, inv_in;
   logic [IDX_W-1:0]   load_cnt_ff, load_cnt_in;
   logic [1:0]         pass_ff, pass_in;
   logic [IDX_W-1:0]   elem_ff, elem_in;
   logic [COORD_W-1:0] cc_ff, cc_in, rr_ff, rr_in, dd_ff, dd_in;
   logic [COORD_W-1:0] term_ff, term_in;

   logic [WORK_W-1:0]  mem [0:2*64-1];
   logic [WORK_W-1:0]  rdata_ff;
   logic [IDX_W:0]     mem_raddr, mem_waddr;
   logic [WORK_W-1:0]  mem_wdata;
   logic               mem_we;

   mac_ctl_type              mac_ctl;
   logic signed [ACC_W-1:0]  acc;
   logic                     mac_last;
   logic signed [COEF_W-1:0] coef;
   logic [COORD_W-1:0]       len_max, axis, ds, rs, cs;
   logic [IDX_W-1:0]         src_addr;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [WORK_W-1:0] out_value;
   logic                     in_take, cfg_write, elem_last;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_MODE);
   assign csr_prdata = {31'd0, mode_ff};
   assign mode_in    = cfg_write ? csr_pwdata[0] : mode_ff;

   // Handshakes.
   assign req_stall = (state_ff != S_LOAD);
   assign in_take   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_SHOW);

   // Source coordinates: the pass axis is replaced by the term counter.
   always_comb begin
      len_max = (pass_ff == 2'd2) ? DEPTH_MAX : SIDE_MAX;
      cs = cc_ff;
      rs = rr_ff;
      ds = dd_ff;
      unique case (pass_ff)
         2'd0: begin
            axis = cc_ff;
            cs   = term_ff;
         end
         2'd1: begin
            axis = rr_ff;
            rs   = term_ff;
         end
         default: begin
            axis = dd_ff;
            ds   = term_ff;
         end
      endcase
      src_addr = IDX_W'(int'(ds) * BLOCK_SIDE * BLOCK_SIDE + int'(rs) * BLOCK_SIDE
                        + int'(cs));
      coef = inv_ff ? cos_coef(len_max, term_ff, axis) : cos_coef(len_max, axis, term_ff);
   end

   // Rounding shift of the finished sum, half up.
   always_comb begin
      unique case (pass_ff)
         2'd0:    rounded = (acc + (ACC_W'(1) <<< 7)) >>> 8;
         2'd1:    rounded = (acc + (ACC_W'(1) <<< 15)) >>> 16;
         default: rounded = (acc + (ACC_W'(1) <<< 23)) >>> 24;
      endcase
   end

   assign elem_last = ({1'b0, elem_ff} == TOTAL - (IDX_W+1)'(1));

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      inv_in      = inv_ff;
      load_cnt_in = load_cnt_ff;
      pass_in     = pass_ff;
      elem_in     = elem_ff;
      cc_in       = cc_ff;
      rr_in       = rr_ff;
      dd_in       = dd_ff;
      term_in     = term_ff;
      mac_ctl     = '0;
      mem_we      = 1'b0;
      mem_waddr   = {1'b0, load_cnt_ff};
      mem_wdata   = WORK_W'(req_sample);
      mem_raddr   = {pass_ff[0], src_addr};
      unique case (state_ff)
         S_LOAD: begin
            if (in_take) begin
               mem_we = 1'b1;
               if ({1'b0, load_cnt_ff} == TOTAL - (IDX_W+1)'(1)) begin
                  load_cnt_in = '0;
                  inv_in      = mode_ff;
                  pass_in     = '0;
                  elem_in     = '0;
                  cc_in       = '0;
                  rr_in       = '0;
                  dd_in       = '0;
                  term_in     = '0;
                  mac_ctl.clear = 1'b1;
                  state_in    = S_RD;
               end else begin
                  load_cnt_in = load_cnt_ff + IDX_W'(1);
               end
            end
         end
         S_RD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            mac_ctl.load = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            mac_ctl.run = 1'b1;
            if (mac_last) begin
               if (term_ff == len_max) begin
                  state_in = S_WR;
               end else begin
                  term_in  = term_ff + COORD_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_WR: begin
            mem_we        = 1'b1;
            mem_waddr     = {~pass_ff[0], elem_ff};
            mem_wdata     = rounded[WORK_W-1:0];
            mac_ctl.clear = 1'b1;
            term_in       = '0;
            elem_in       = elem_ff + IDX_W'(1);
            if (cc_ff == SIDE_MAX) begin
               cc_in = '0;
               if (rr_ff == SIDE_MAX) begin
                  rr_in = '0;
                  dd_in = (dd_ff == DEPTH_MAX) ? '0 : dd_ff + COORD_W'(1);
               end else begin
                  rr_in = rr_ff + COORD_W'(1);
               end
            end else begin
               cc_in = cc_ff + COORD_W'(1);
            end
            if (elem_last) begin
               elem_in = '0;
               cc_in   = '0;
               rr_in   = '0;
               dd_in   = '0;
               if (pass_ff == 2'd2) begin
                  state_in = S_ORD;
               end else begin
                  pass_in  = pass_ff + 2'd1;
                  state_in = S_RD;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_ORD: begin
            mem_raddr = {1'b1, elem_ff};
            state_in  = S_SHOW;
         end
         S_SHOW: begin
            mem_raddr = {1'b1, elem_ff};
            if (!rsp_stall) begin
               if (elem_last) begin
                  elem_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  elem_in  = elem_ff + IDX_W'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Work memory: one array holds two ping-pong banks, and the load bank is the first of them.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         mode_ff     <= 1'b0;
         inv_ff      <= 1'b0;
         load_cnt_ff <= '0;
         pass_ff     <= '0;
         elem_ff     <= '0;
         cc_ff       <= '0;
         rr_ff       <= '0;
         dd_ff       <= '0;
         term_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         inv_ff      <= inv_in;
         load_cnt_ff <= load_cnt_in;
         pass_ff     <= pass_in;
         elem_ff     <= elem_in;
         cc_ff       <= cc_in;
         rr_ff       <= rr_in;
         dd_ff       <= dd_in;
         term_ff     <= term_in;
      end
   end

   // Serial multiply-accumulate unit.
   dct3d_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .x_value  (rdata_ff),
      .c_value  (coef),
      .acc_out  (acc),
      .last_bit (mac_last)
   );

   // Output item with saturation.
   always_comb begin
      out_value = rdata_ff;
      if (out_value > SAT_MAX) begin
         out_value = SAT_MAX;
      end else if (out_value < SAT_MIN) begin
         out_value = SAT_MIN;
      end
   end

   assign rsp_coefficient = out_value[SAMPLE_W-1:0];
   assign rsp_out_index   = elem_ff;
   assign rsp_last        = elem_last;

`ifndef NO_ASSERTIONS
   // The final item of a cube carries the last index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> {1'b0, rsp_out_index} == TOTAL - (IDX_W+1)'(1))
      else $error("last flag on wrong index");
   // Samples are only taken while the load counter is inside the cube.
   a_load_range: assert property (@(posedge clock) disable iff (reset)
      in_take |-> {1'b0, load_cnt_ff} < TOTAL)
      else $error("load counter out of range");
   // A completed cube moves straight into processing.
   a_cube_start: assert property (@(posedge clock) disable iff (reset)
      in_take && ({1'b0, load_cnt_ff} == TOTAL - (IDX_W+1)'(1)) |=> state_ff == S_RD)
      else $error("cube did not start");
   // A stalled item keeps its index.
   a_hold_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_index))
      else $error("stalled item changed");
`endif

endmodule

// ===== tb/dct_3d_block_fwd_inv_tb.sv =====
// Self-checking testbench for the 3D DCT-II / DCT-III cube transform block.
`timescale 1ns / 1ps

module dct_3d_block_fwd_inv_tb;
   import dct3d_pkg::*;

   localparam int CUBE_SIZE   = 64;
   localparam int STALL_LIMIT = 100000;
   localparam int SETTLE      = 40;
   localparam logic [2:0] MODE_ADDR = 3'd0;

   // One expected output element.
   typedef struct {
      logic signed [SAMPLE_W-1:0] coefficient;
      logic [IDX_W-1:0]           out_index;
      logic                       last;
   } coef_item_type;

   // Scoreboard: collects samples into a cube, transforms it and holds the coefficients.
   class cube_scoreboard_type;
      logic signed [SAMPLE_W-1:0] cube_samples [CUBE_SIZE];
      int                         fill_level;
      bit                         inverse;
      coef_item_type              coef_queue [$];

      function new();
         fill_level = 0;
         inverse    = 0;
      endfunction

      // Orthonormal 4-point cosine entry, scaled by 2^16.
      function longint cos4(int k, int n);
         case (k*4 + n)
            0, 1, 2, 3, 8, 11: return 32768;
            9, 10:             return -32768;
            4, 14:             return 42813;
            5, 12:             return 17734;
            6, 15:             return -17734;
            7, 13:             return -42813;
            default:           return 0;
         endcase
      endfunction

      // One 4-point transform along a line of the work cube, rounding half up.
      function void axis_pass(ref longint w [CUBE_SIZE], input int base, input int stride,
                              input int shift);
         longint x [4];
         longint acc;
         for (int a = 0; a < 4; a++) x[a] = w[base + a*stride];
         for (int a = 0; a < 4; a++) begin
            acc = 0;
            for (int b = 0; b < 4; b++)
               acc += x[b] * (inverse ? cos4(b, a) : cos4(a, b));
            w[base + a*stride] = (acc + (64'sd1 <<< (shift-1))) >>> shift;
         end
      endfunction

      // Transform a full cube and queue its 64 coefficients.
      function void transform_cube();
         longint        w [CUBE_SIZE];
         coef_item_type it;
         for (int i = 0; i < CUBE_SIZE; i++) w[i] = longint'(cube_samples[i]);
         for (int l = 0; l < 16; l++) axis_pass(w, l*4, 1, 8);
         for (int d = 0; d < 4; d++)
            for (int c = 0; c < 4; c++) axis_pass(w, d*16 + c, 4, 16);
         for (int l = 0; l < 16; l++) axis_pass(w, l, 16, 24);
         for (int i = 0; i < CUBE_SIZE; i++) begin
            if (w[i] > 8388607) w[i] = 8388607;
            if (w[i] < -8388608) w[i] = -8388608;
            it.coefficient = w[i][SAMPLE_W-1:0];
            it.out_index   = i[IDX_W-1:0];
            it.last        = (i == CUBE_SIZE-1);
            coef_queue.push_back(it);
         end
      endfunction

      // Note an accepted sample; the mode is taken when the cube completes.
      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         cube_samples[fill_level] = s;
         fill_level++;
         if (fill_level == CUBE_SIZE) begin
            fill_level = 0;
            transform_cube();
         end
      endfunction

      // Compare a result item with the oldest expectation; returns a mismatch text or "".
      function string check_result(logic signed [SAMPLE_W-1:0] coef, logic [IDX_W-1:0] idx,
                                   logic lst);
         coef_item_type e;
         if (coef_queue.size() == 0)
            return $sformatf("unexpected item idx=%0d coef=%0d", idx, coef);
         e = coef_queue.pop_front();
         if (coef !== e.coefficient || idx !== e.out_index || lst !== e.last)
            return $sformatf("idx %0d: got coef=%0d idx=%0d last=%0b, want %0d/%0d/%0b",
                             e.out_index, coef, idx, lst, e.coefficient, e.out_index,
                             e.last);
         return "";
      endfunction
   endclass

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 0;
   logic signed [SAMPLE_W-1:0] rsp_coefficient;
   logic [IDX_W-1:0]           rsp_out_index;
   logic                       rsp_last;
   logic                       csr_psel = 0;
   logic                       csr_penable = 0;
   logic                       csr_pwrite = 0;
   logic [2:0]                 csr_paddr = '0;
   logic [31:0]                csr_pwdata = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   cube_scoreboard_type sb = new();
   int  mismatches = 0;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  hold_armed = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   dct_3d_block_fwd_inv u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_coefficient(rsp_coefficient),
      .rsp_out_index(rsp_out_index), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Print one mismatch line and count it.
   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // Result side: check accepted items, choose the next stall, run the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         string msg;
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[dct_3d_block_fwd_inv] ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            msg = sb.check_result(rsp_coefficient, rsp_out_index, rsp_last);
            if (msg != "") report_mismatch(msg);
         end
         // A long hold-off starts at the first result once armed.
         if (hold_armed && rsp_valid && hold_left == 0) begin
            hold_armed = 0;
            hold_left  = 3000;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   // Offer one sample, idling at random first, and wait until it is taken.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid  <= 1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
   endtask

   // Write the mode register through a setup and an access cycle.
   task automatic write_mode(bit inv);
      req_valid   <= 0;
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {31'($urandom_range(32'h7FFF_FFFF)), inv};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      sb.inverse = inv;
      @(posedge clock);
   endtask

   // Wait until every expected coefficient has arrived, then let the block settle.
   task automatic drain_results();
      req_valid <= 0;
      while (sb.coef_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random sample: extremes with sat_bias percent chance, small values with 20 percent, else full range.
   function automatic logic signed [SAMPLE_W-1:0] random_sample(int sat_bias);
      int r;
      r = $urandom_range(99);
      if (r < sat_bias) return ($urandom_range(1) ? 24'sh7FFFFF : 24'sh800000);
      if (r < sat_bias + 20) return SAMPLE_W'($signed($urandom_range(2047)) - 1024);
      return SAMPLE_W'($urandom);
   endfunction

   initial begin
      logic signed [SAMPLE_W-1:0] directed [25];
      directed = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000001, 24'shFFFFFF,
                   24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh000100,
                   24'shFFFF00, 24'sh555555, 24'shAAAAAA, 24'sh000080, 24'shFFFF80,
                   24'sh400000, 24'shC00000, 24'sh7FFFFF, 24'sh800000, 24'sh000000,
                   24'sh7FFF00, 24'sh800100, 24'sh0000FF, 24'shFFFF01, 24'sh123456};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Forward mode, a seldom idle sender and a busy receiver: directed items then random.
      tx_idle_pct = 10;
      rx_idle_pct = 53;
      write_mode(0);
      foreach (directed[i]) send_sample(directed[i]);
      repeat (CUBE_SIZE - 25) send_sample(random_sample(10));
      drain_results();

      // Inverse mode with the idling swapped.
      tx_idle_pct = 53;
      rx_idle_pct = 10;
      write_mode(1);
      repeat (CUBE_SIZE) send_sample(random_sample(15));
      drain_results();

      // Forward again, saturating data, no idling, a long receiver hold-off,
      // and the sender keeps offering a partial next cube.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_mode(0);
      hold_armed = 1;
      repeat (CUBE_SIZE + 20) send_sample(random_sample(70));
      drain_results();

      if (mismatches == 0 && sb.coef_queue.size() == 0) begin
         $display("[dct_3d_block_fwd_inv] OK");
      end else begin
         $display("[dct_3d_block_fwd_inv] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dct3d_pkg.sv
rtl/dct3d_mac.sv
rtl/dct_3d_block_fwd_inv.sv
tb/dct_3d_block_fwd_inv_tb.sv
